@@ rtl/core/bdwd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdwd_pkg
// Shared types, codes and helpers of the binary delta window decoder.
// ----------------------------------------------------------------------------
package bdwd_pkg;

  localparam int unsigned SOURCE_DEPTH_DEF     = 131072;
  localparam int unsigned WINDOW_DEPTH_DEF     = 131072;
  localparam int unsigned TARGET_DEPTH_DEF     = 131072;
  localparam int unsigned MAX_VARINT_BYTES_DEF = 10;

  localparam int unsigned VCNT_W = 4;   // holds up to the longest varint

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_FIRST  = 3'd1;
  localparam logic [2:0] PH_BODY   = 3'd6;
  localparam logic [2:0] PH_DONE   = 3'd7;

  typedef enum logic [1:0] {
    CMD_LOAD_SRC   = 2'd0,
    CMD_DELTA      = 2'd1,
    CMD_READ_TGT   = 2'd2,
    CMD_NEW_STREAM = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_WIN_DONE = 3'd1,
    STAT_BAD_HDR  = 3'd2,
    STAT_BROKEN   = 3'd3,
    STAT_BAD_OP   = 3'd4,
    STAT_ZERO_LEN = 3'd5,
    STAT_RANGE    = 3'd6,
    STAT_READ     = 3'd7
  } stat_e;

  localparam logic [1:0] OP_SRC  = 2'd0;
  localparam logic [1:0] OP_TGT  = 2'd1;
  localparam logic [1:0] OP_NEW  = 2'd2;
  localparam logic [1:0] OP_BAD  = 2'd3;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  byte_value;
    logic [16:0] address;
    logic        last_byte;
  } item_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h53;
      2'd1:    m = 8'h56;
      2'd2:    m = 8'h4E;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // shift in seven bits, saturating once the value would pass 32 bits
  function automatic logic [31:0] push7(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    if (acc > 32'h01FF_FFFF) r = 32'hFFFF_FFFF;
    else                     r = {acc[24:0], b[6:0]};
    return r;
  endfunction

endpackage

@@ rtl/core/binary_delta_window_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_delta_window_decoder
// svndiff0 delta decoder: header check, window buffering and execution.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle into a 2-deep queue while it has room; the
// back end retires one simple item per cycle while the output is not stalled.
// A completed window runs opcode by opcode: opcode read and decode, varint
// reads, range check, then a byte read and a byte write per target byte.
// Reset: asynchronous, active low; parser idle, no error; stores undefined.
// ----------------------------------------------------------------------------
module binary_delta_window_decoder #(
  parameter int unsigned SOURCE_DEPTH     = bdwd_pkg::SOURCE_DEPTH_DEF,
  parameter int unsigned WINDOW_DEPTH     = bdwd_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned TARGET_DEPTH     = bdwd_pkg::TARGET_DEPTH_DEF,
  parameter int unsigned MAX_VARINT_BYTES = bdwd_pkg::MAX_VARINT_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // command[1:0], byte_value[9:2], address[26:10]
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // status[2:0], data_byte[10:3], target_length[28:11]
);

  logic            q_valid;
  bdwd_pkg::item_t q_item;
  logic            q_pop;
  logic [2:0]      status;
  logic [7:0]      data_byte;
  logic [17:0]     target_length;

  bdwd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  bdwd_back #(
    .SOURCE_DEPTH     (SOURCE_DEPTH),
    .WINDOW_DEPTH     (WINDOW_DEPTH),
    .TARGET_DEPTH     (TARGET_DEPTH),
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (status),
    .out_data_o   (data_byte),
    .out_len_o    (target_length)
  );

  assign m_axis_tdata_o = {3'b000, target_length, data_byte, status};

endmodule

@@ rtl/core/bdwd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdwd_front
// Input side: unpacks beats, decodes the command and queues items (2 deep).
// ----------------------------------------------------------------------------
module bdwd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [31:0]      in_data_i,
  input  logic             in_last_i,
  output logic             q_valid_o,
  output bdwd_pkg::item_t  q_item_o,
  input  logic             q_pop_i
);

  bdwd_pkg::item_t item_mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  bdwd_pkg::item_t in_item;
  logic            push;
  logic            pop;

  always_comb begin
    in_item.command    = bdwd_pkg::cmd_e'(in_data_i[1:0]);
    in_item.byte_value = in_data_i[9:2];
    in_item.address    = in_data_i[26:10];
    in_item.last_byte  = in_last_i;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = item_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      item_mem_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

@@ rtl/core/bdwd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdwd_back
// Executes queued items: source loads, stream resets, header/size parsing,
// window buffering, window execution into the target store and target reads.
// ----------------------------------------------------------------------------
module bdwd_back #(
  parameter int unsigned SOURCE_DEPTH     = bdwd_pkg::SOURCE_DEPTH_DEF,
  parameter int unsigned WINDOW_DEPTH     = bdwd_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned TARGET_DEPTH     = bdwd_pkg::TARGET_DEPTH_DEF,
  parameter int unsigned MAX_VARINT_BYTES = bdwd_pkg::MAX_VARINT_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  bdwd_pkg::item_t  q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       out_status_o,
  output logic [7:0]       out_data_o,
  output logic [17:0]      out_len_o
);

  localparam int unsigned SAW = $clog2(SOURCE_DEPTH);
  localparam int unsigned WAW = $clog2(WINDOW_DEPTH);
  localparam int unsigned TAW = $clog2(TARGET_DEPTH);
  localparam int unsigned WLW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned TLW = $clog2(TARGET_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_OP   = 9'b000000100,
    S_OPD  = 9'b000001000,
    S_VAR  = 9'b000010000,
    S_VARD = 9'b000100000,
    S_CHK  = 9'b001000000,
    S_CPRD = 9'b010000000,
    S_CPWR = 9'b100000000
  } state_e;

  logic [7:0] src_mem [SOURCE_DEPTH];
  logic [7:0] wb_mem  [WINDOW_DEPTH];
  logic [7:0] tgt_mem [TARGET_DEPTH];

  logic           src_we, src_re, wb_we, wb_re, tgt_we, tgt_re;
  logic [SAW-1:0] src_wa, src_ra;
  logic [WAW-1:0] wb_wa, wb_ra;
  logic [TAW-1:0] tgt_wa, tgt_ra;
  logic [7:0]     src_wd, wb_wd, tgt_wd;
  logic [7:0]     src_q, wb_q, tgt_q;

  state_e          state_q, state_d;
  logic [2:0]      phase_q, phase_d;
  logic [2:0]      hc_q, hc_d;
  logic [31:0]     vacc_q, vacc_d;
  logic [VCNT_W_L-1:0] vcnt_q, vcnt_d;
  logic [31:0]     sizes_q [5];
  logic [31:0]     sizes_d [5];
  logic [WLW-1:0]  sf_q, sf_d;
  bdwd_pkg::stat_e err_q, err_d;
  logic [TLW-1:0]  prod_q, prod_d;
  logic            last_q, last_d;
  logic [WLW-1:0]  ip_q, ip_d;
  logic [WLW-1:0]  nd_q, nd_d;
  logic [TLW-1:0]  outn_q, outn_d;
  logic [1:0]      op_q, op_d;
  logic [31:0]     len_q, len_d;
  logic [31:0]     off_q, off_d;
  logic            sel_off_q, sel_off_d;
  logic [31:0]     xacc_q, xacc_d;
  logic [VCNT_W_L-1:0] xcnt_q, xcnt_d;
  logic [31:0]     rptr_q, rptr_d;
  logic [31:0]     cnt_q, cnt_d;
  logic            rd_ok_q, rd_ok_d;
  logic            out_v_q, out_v_d;
  logic [2:0]      out_stat_q, out_stat_d;
  logic [7:0]      out_data_q, out_data_d;
  logic [17:0]     out_len_q, out_len_d;

  localparam int unsigned VCNT_W_L = bdwd_pkg::VCNT_W;

  logic            do_fail;
  bdwd_pkg::stat_e fail_code;
  logic            emit;
  bdwd_pkg::stat_e emit_stat;
  logic [7:0]      emit_data;
  logic            out_free;
  logic [31:0]     addr_ext;
  logic [31:0]     acc_n;
  logic [32:0]     sec_sum;
  logic [31:0]     tl_ext;
  logic [7:0]      cp_byte;
  logic [2:0]      size_idx;

  assign out_free    = !out_v_q || out_ready_i;
  assign addr_ext    = 32'(q_item_i.address);
  assign sec_sum     = 33'(sizes_q[3]) + 33'(sizes_q[4]);
  assign out_valid_o = out_v_q;
  assign out_status_o = out_stat_q;
  assign out_data_o  = out_data_q;
  assign out_len_o   = out_len_q;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    hc_d      = hc_q;
    vacc_d    = vacc_q;
    vcnt_d    = vcnt_q;
    sizes_d   = sizes_q;
    sf_d      = sf_q;
    err_d     = err_q;
    prod_d    = prod_q;
    last_d    = last_q;
    ip_d      = ip_q;
    nd_d      = nd_q;
    outn_d    = outn_q;
    op_d      = op_q;
    len_d     = len_q;
    off_d     = off_q;
    sel_off_d = sel_off_q;
    xacc_d    = xacc_q;
    xcnt_d    = xcnt_q;
    rptr_d    = rptr_q;
    cnt_d     = cnt_q;
    rd_ok_d   = rd_ok_q;
    do_fail   = 1'b0;
    fail_code = bdwd_pkg::STAT_OK;
    emit      = 1'b0;
    emit_stat = bdwd_pkg::STAT_OK;
    emit_data = 8'h00;
    q_pop_o   = 1'b0;
    src_we = 1'b0; src_wa = addr_ext[SAW-1:0]; src_wd = q_item_i.byte_value;
    src_re = 1'b0; src_ra = rptr_q[SAW-1:0];
    wb_we  = 1'b0; wb_wa  = 32'(sf_q)  >> 0 == 32'(sf_q) ? sf_q[WAW-1:0] : '0;
    wb_wd  = q_item_i.byte_value;
    wb_re  = 1'b0; wb_ra  = ip_q[WAW-1:0];
    tgt_we = 1'b0; tgt_wa = outn_q[TAW-1:0]; tgt_wd = 8'h00;
    tgt_re = 1'b0; tgt_ra = addr_ext[TAW-1:0];
    acc_n    = 32'h0;
    cp_byte  = 8'h00;
    size_idx = phase_q - 3'd1;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          case (q_item_i.command)
            bdwd_pkg::CMD_LOAD_SRC: begin
              emit = 1'b1;
              if (addr_ext < 32'(SOURCE_DEPTH)) begin
                src_we = 1'b1;
              end else begin
                emit_stat = bdwd_pkg::STAT_RANGE;
              end
            end
            bdwd_pkg::CMD_READ_TGT: begin
              tgt_re  = 1'b1;
              rd_ok_d = (addr_ext < 32'(prod_q)) && (addr_ext < 32'(TARGET_DEPTH));
              state_d = S_RD;
            end
            bdwd_pkg::CMD_NEW_STREAM: begin
              emit    = 1'b1;
              phase_d = bdwd_pkg::PH_HEADER;
              hc_d    = 3'd0;
              vacc_d  = 32'h0;
              vcnt_d  = '0;
              for (int k = 0; k < 5; k++) sizes_d[k] = 32'h0;
              sf_d    = '0;
              err_d   = bdwd_pkg::STAT_OK;
              prod_d  = '0;
            end
            default: begin
              // delta byte
              if (err_q != bdwd_pkg::STAT_OK) begin
                emit      = 1'b1;
                emit_stat = err_q;
              end else if (phase_q == bdwd_pkg::PH_DONE) begin
                emit = 1'b1;
              end else if (phase_q == bdwd_pkg::PH_HEADER) begin
                emit = 1'b1;
                if (q_item_i.byte_value != bdwd_pkg::magic_byte(hc_q[1:0])) begin
                  do_fail   = 1'b1;
                  fail_code = bdwd_pkg::STAT_BAD_HDR;
                end else begin
                  hc_d = hc_q + 3'd1;
                  if (hc_d >= 3'd4) phase_d = bdwd_pkg::PH_FIRST;
                  if (q_item_i.last_byte) begin
                    if (hc_d < 3'd4) begin
                      do_fail   = 1'b1;
                      fail_code = bdwd_pkg::STAT_BAD_HDR;
                    end else begin
                      phase_d = bdwd_pkg::PH_DONE;
                    end
                  end
                end
              end else if (phase_q < bdwd_pkg::PH_BODY) begin
                acc_n  = bdwd_pkg::push7(vacc_q, q_item_i.byte_value);
                vacc_d = acc_n;
                vcnt_d = vcnt_q + 1'b1;
                if (q_item_i.byte_value[7]) begin
                  emit = 1'b1;
                  if (32'(vcnt_d) >= 32'(MAX_VARINT_BYTES) || q_item_i.last_byte) begin
                    do_fail   = 1'b1;
                    fail_code = bdwd_pkg::STAT_BROKEN;
                  end
                end else begin
                  sizes_d[size_idx] = acc_n;
                  vacc_d  = 32'h0;
                  vcnt_d  = '0;
                  phase_d = phase_q + 3'd1;
                  emit    = 1'b1;
                  if (phase_d == bdwd_pkg::PH_BODY) begin
                    sf_d = '0;
                    if ((33'(sizes_d[3]) + 33'(sizes_d[4]) > 33'(WINDOW_DEPTH)) ||
                        (sizes_d[2] > 32'(TARGET_DEPTH)) ||
                        (33'(sizes_d[0]) + 33'(sizes_d[1]) > 33'(SOURCE_DEPTH))) begin
                      do_fail   = 1'b1;
                      fail_code = bdwd_pkg::STAT_RANGE;
                    end else if (33'(sizes_d[3]) + 33'(sizes_d[4]) == 33'd0) begin
                      emit    = 1'b0;
                      last_d  = q_item_i.last_byte;
                      ip_d    = '0;
                      nd_d    = '0;
                      outn_d  = '0;
                      state_d = S_OP;
                    end else if (q_item_i.last_byte) begin
                      do_fail   = 1'b1;
                      fail_code = bdwd_pkg::STAT_BROKEN;
                    end
                  end else if (q_item_i.last_byte) begin
                    do_fail   = 1'b1;
                    fail_code = bdwd_pkg::STAT_BROKEN;
                  end
                end
              end else begin
                // section fill
                wb_we = 1'b1;
                sf_d  = sf_q + 1'b1;
                if (33'(sf_d) >= sec_sum) begin
                  last_d  = q_item_i.last_byte;
                  ip_d    = '0;
                  nd_d    = sizes_q[3][WLW-1:0];
                  outn_d  = '0;
                  state_d = S_OP;
                end else begin
                  emit = 1'b1;
                  if (q_item_i.last_byte) begin
                    do_fail   = 1'b1;
                    fail_code = bdwd_pkg::STAT_BROKEN;
                  end
                end
              end
            end
          endcase
        end
      end

      S_RD: begin
        emit      = 1'b1;
        emit_stat = bdwd_pkg::STAT_READ;
        emit_data = rd_ok_q ? tgt_q : 8'h00;
        state_d   = S_IDLE;
      end

      S_OP: begin
        if (32'(ip_q) >= sizes_q[3]) begin
          if (32'(outn_q) != sizes_q[2]) begin
            do_fail   = 1'b1;
            fail_code = bdwd_pkg::STAT_RANGE;
          end else begin
            emit      = 1'b1;
            emit_stat = bdwd_pkg::STAT_WIN_DONE;
            prod_d    = outn_q;
            phase_d   = last_q ? bdwd_pkg::PH_DONE : bdwd_pkg::PH_FIRST;
            sf_d      = '0;
            state_d   = S_IDLE;
          end
        end else begin
          wb_re   = 1'b1;
          ip_d    = ip_q + 1'b1;
          state_d = S_OPD;
        end
      end

      S_OPD: begin
        op_d   = wb_q[7:6];
        len_d  = 32'(wb_q[5:0]);
        xacc_d = 32'h0;
        xcnt_d = '0;
        if (wb_q[7:6] == bdwd_pkg::OP_BAD) begin
          do_fail   = 1'b1;
          fail_code = bdwd_pkg::STAT_BAD_OP;
        end else if (wb_q[5:0] == 6'd0) begin
          sel_off_d = 1'b0;
          state_d   = S_VAR;
        end else if (wb_q[7:6] != bdwd_pkg::OP_NEW) begin
          sel_off_d = 1'b1;
          state_d   = S_VAR;
        end else begin
          state_d = S_CHK;
        end
      end

      S_VAR: begin
        if (32'(ip_q) >= sizes_q[3]) begin
          do_fail   = 1'b1;
          fail_code = bdwd_pkg::STAT_BROKEN;
        end else begin
          wb_re   = 1'b1;
          ip_d    = ip_q + 1'b1;
          state_d = S_VARD;
        end
      end

      S_VARD: begin
        acc_n  = bdwd_pkg::push7(xacc_q, wb_q);
        xacc_d = acc_n;
        xcnt_d = xcnt_q + 1'b1;
        if (wb_q[7]) begin
          if (32'(xcnt_d) >= 32'(MAX_VARINT_BYTES)) begin
            do_fail   = 1'b1;
            fail_code = bdwd_pkg::STAT_BROKEN;
          end else begin
            state_d = S_VAR;
          end
        end else if (!sel_off_q) begin
          len_d = acc_n;
          if (acc_n == 32'h0) begin
            do_fail   = 1'b1;
            fail_code = bdwd_pkg::STAT_ZERO_LEN;
          end else if (op_q != bdwd_pkg::OP_NEW) begin
            sel_off_d = 1'b1;
            xacc_d    = 32'h0;
            xcnt_d    = '0;
            state_d   = S_VAR;
          end else begin
            state_d = S_CHK;
          end
        end else begin
          off_d   = acc_n;
          state_d = S_CHK;
        end
      end

      S_CHK: begin
        cnt_d   = len_q;
        state_d = S_CPRD;
        if (33'(outn_q) + 33'(len_q) > 33'(sizes_q[2])) begin
          do_fail   = 1'b1;
          fail_code = bdwd_pkg::STAT_RANGE;
        end else if (op_q == bdwd_pkg::OP_SRC) begin
          rptr_d = sizes_q[0] + off_q;
          if (33'(off_q) + 33'(len_q) > 33'(sizes_q[1])) begin
            do_fail   = 1'b1;
            fail_code = bdwd_pkg::STAT_RANGE;
          end
        end else if (op_q == bdwd_pkg::OP_TGT) begin
          rptr_d = off_q;
          if (off_q >= 32'(outn_q)) begin
            do_fail   = 1'b1;
            fail_code = bdwd_pkg::STAT_RANGE;
          end
        end else begin
          rptr_d = 32'(nd_q);
          if (33'(nd_q) + 33'(len_q) > sec_sum) begin
            do_fail   = 1'b1;
            fail_code = bdwd_pkg::STAT_RANGE;
          end
        end
      end

      S_CPRD: begin
        src_ra = rptr_q[SAW-1:0];
        wb_ra  = rptr_q[WAW-1:0];
        tgt_ra = rptr_q[TAW-1:0];
        src_re = (op_q == bdwd_pkg::OP_SRC);
        tgt_re = (op_q == bdwd_pkg::OP_TGT);
        wb_re  = (op_q == bdwd_pkg::OP_NEW);
        rptr_d  = rptr_q + 32'd1;
        state_d = S_CPWR;
      end

      S_CPWR: begin
        case (op_q)
          bdwd_pkg::OP_SRC: cp_byte = src_q;
          bdwd_pkg::OP_TGT: cp_byte = tgt_q;
          default:          cp_byte = wb_q;
        endcase
        tgt_we = 1'b1;
        tgt_wd = cp_byte;
        outn_d = outn_q + 1'b1;
        cnt_d  = cnt_q - 32'd1;
        if (op_q == bdwd_pkg::OP_NEW) nd_d = nd_q + 1'b1;
        state_d = (cnt_q == 32'd1) ? S_OP : S_CPRD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (do_fail) begin
      err_d     = fail_code;
      prod_d    = '0;
      emit      = 1'b1;
      emit_stat = fail_code;
      emit_data = 8'h00;
      state_d   = S_IDLE;
    end

    out_v_d    = out_v_q && !out_ready_i;
    out_stat_d = out_stat_q;
    out_data_d = out_data_q;
    out_len_d  = out_len_q;
    tl_ext     = 32'(prod_d);
    if (emit) begin
      out_v_d    = 1'b1;
      out_stat_d = emit_stat;
      out_data_d = emit_data;
      out_len_d  = tl_ext[17:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= bdwd_pkg::PH_HEADER;
      hc_q      <= 3'd0;
      vacc_q    <= 32'h0;
      vcnt_q    <= '0;
      for (int k = 0; k < 5; k++) sizes_q[k] <= 32'h0;
      sf_q      <= '0;
      err_q     <= bdwd_pkg::STAT_OK;
      prod_q    <= '0;
      last_q    <= 1'b0;
      ip_q      <= '0;
      nd_q      <= '0;
      outn_q    <= '0;
      op_q      <= bdwd_pkg::OP_SRC;
      len_q     <= 32'h0;
      off_q     <= 32'h0;
      sel_off_q <= 1'b0;
      xacc_q    <= 32'h0;
      xcnt_q    <= '0;
      rptr_q    <= 32'h0;
      cnt_q     <= 32'h0;
      rd_ok_q   <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      hc_q      <= hc_d;
      vacc_q    <= vacc_d;
      vcnt_q    <= vcnt_d;
      sizes_q   <= sizes_d;
      sf_q      <= sf_d;
      err_q     <= err_d;
      prod_q    <= prod_d;
      last_q    <= last_d;
      ip_q      <= ip_d;
      nd_q      <= nd_d;
      outn_q    <= outn_d;
      op_q      <= op_d;
      len_q     <= len_d;
      off_q     <= off_d;
      sel_off_q <= sel_off_d;
      xacc_q    <= xacc_d;
      xcnt_q    <= xcnt_d;
      rptr_q    <= rptr_d;
      cnt_q     <= cnt_d;
      rd_ok_q   <= rd_ok_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_stat_q <= out_stat_d;
    out_data_q <= out_data_d;
    out_len_q  <= out_len_d;
  end

  always_ff @(posedge clk_i) begin
    if (src_we) src_mem[src_wa] <= src_wd;
    if (src_re) src_q <= src_mem[src_ra];
  end

  always_ff @(posedge clk_i) begin
    if (wb_we) wb_mem[wb_wa] <= wb_wd;
    if (wb_re) wb_q <= wb_mem[wb_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tgt_we) tgt_mem[tgt_wa] <= tgt_wd;
    if (tgt_re) tgt_q <= tgt_mem[tgt_ra];
  end

endmodule
